// ===== hdl/pol_pkg.sv =====
// shared constants and types for the positional ordered list
`default_nettype none
package pol_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_LOCATE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] tgt;
        logic [7:0]       value;
    } cell_op_t;

endpackage
`default_nettype wire

// ===== hdl/pol_req_if.sv =====
// request channel: mode, position and value
`default_nettype none
interface pol_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [4:0] position;
    logic [7:0] value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);
endinterface
`default_nettype wire

// ===== hdl/pol_rsp_if.sv =====
// result channel: status, read value, found position, length, empty flag
`default_nettype none
interface pol_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] read_value;
    logic [4:0] found_position;
    logic [4:0] list_length;
    logic       is_empty;

    modport source (output valid, status, read_value, found_position, list_length, is_empty,
                    input ready);
    modport sink   (input valid, status, read_value, found_position, list_length, is_empty,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/pol_cell.sv =====
// one list cell: holds an entry, shifts with its neighbours, joins the read and match chains
`default_nettype none
module pol_cell
    import pol_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  cell_op_t         op,
    input  logic [7:0]       left,
    input  logic [7:0]       right,
    input  logic [CNT_W-1:0] count,
    input  logic             hit_in,
    input  logic [CNT_W-1:0] fpos_in,
    input  logic [7:0]       rd_in,
    output logic [7:0]       entry,
    output logic             hit_out,
    output logic [CNT_W-1:0] fpos_out,
    output logic [7:0]       rd_out
);

    logic [7:0] entry_reg;
    logic [7:0] entry_next;
    logic       occupied;
    logic       match;

    assign occupied = CNT_W'(idx) < count;
    assign match    = occupied && (entry_reg == op.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins)
        begin
            if (idx > op.tgt)
                entry_next = left;
            else if (idx == op.tgt)
                entry_next = op.value;
        end
        else if (op.del)
        begin
            if (idx >= op.tgt)
                entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // first match wins along the chain
    assign hit_out  = hit_in || match;
    assign fpos_out = hit_in ? fpos_in : (match ? CNT_W'(idx) + CNT_W'(1) : '0);
    assign rd_out   = rd_in | ((idx == op.tgt) ? entry_reg : 8'd0);
    assign entry    = entry_reg;

endmodule
`default_nettype wire

// ===== hdl/positional_ordered_list.sv =====
// top level of the positional ordered list: request decode, cell row, result register
//
// channel  dir  handshake      payload
// req      in   valid/ready    mode, position, value
// rsp      out  valid/ready    status, read_value, found_position, list_length, is_empty
//
// one request is taken per cycle; its result appears in the cycle after acceptance
// the cell row reads and matches in the cycle a request is accepted and shifts at its end
// rst_n clears the length and the result valid flag; entries are not cleared
// a stalled result holds req.ready low until rsp.ready takes it
`default_nettype none
module positional_ordered_list
    import pol_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pol_req_if.sink      req,
    pol_rsp_if.source    rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [7:0]       read_value_reg;
    logic [7:0]       read_value_next;
    logic [4:0]       found_reg;
    logic [4:0]       found_next;
    logic [4:0]       length_reg;
    logic             empty_reg;

    logic             acc;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] found_x;
    logic [CMP_W-1:0] count_x;
    logic             pos_nonzero;
    logic             pos_ok;
    logic             ins_pos_ok;
    logic             has_room;
    logic             ins_ok;
    cell_op_t         op;

    logic [7:0]       entry_w [DEPTH];
    logic             hit_w   [DEPTH+1];
    logic [CNT_W-1:0] fpos_w  [DEPTH+1];
    logic [7:0]       rd_w    [DEPTH+1];

    assign acc       = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign pos_x       = CMP_W'(req.position);
    assign cnt_x       = CMP_W'(count_reg);
    assign pos_m1      = pos_x - CMP_W'(1);
    assign pos_nonzero = pos_x != '0;
    assign pos_ok      = pos_nonzero && (pos_x <= cnt_x);
    assign ins_pos_ok  = pos_nonzero && (pos_x <= cnt_x + CMP_W'(1));
    assign has_room    = count_reg != CNT_W'(DEPTH);
    assign ins_ok      = (req.mode == MODE_INSERT) && has_room && ins_pos_ok;

    assign op.ins   = acc && ins_ok;
    assign op.del   = acc && (req.mode == MODE_DELETE) && pos_ok;
    assign op.tgt   = pos_m1[IDX_W-1:0];
    assign op.value = req.value;

    assign hit_w[0]  = 1'b0;
    assign fpos_w[0] = '0;
    assign rd_w[0]   = 8'd0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] left_w;
        logic [7:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = req.value;
        end
        else
        begin : g_mid
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = entry_w[i];
        end
        else
        begin : g_inner
            assign right_w = entry_w[i+1];
        end

        pol_cell u_cell (
            .clk      (clk),
            .idx      (IDX_W'(i)),
            .op       (op),
            .left     (left_w),
            .right    (right_w),
            .count    (count_reg),
            .hit_in   (hit_w[i]),
            .fpos_in  (fpos_w[i]),
            .rd_in    (rd_w[i]),
            .entry    (entry_w[i]),
            .hit_out  (hit_w[i+1]),
            .fpos_out (fpos_w[i+1]),
            .rd_out   (rd_w[i+1])
        );
    end

    assign found_x = CMP_W'(fpos_w[DEPTH]);

    always_comb
    begin
        count_next      = count_reg;
        status_next     = ST_DONE;
        read_value_next = 8'd0;
        found_next      = 5'd0;
        unique case (req.mode)
            MODE_INSERT:
            begin
                if (!has_room)
                    status_next = ST_FULL;
                else if (!ins_pos_ok)
                    status_next = ST_RANGE;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            MODE_DELETE:
            begin
                if (!pos_ok)
                    status_next = ST_RANGE;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            MODE_READ:
            begin
                if (!pos_ok)
                    status_next = ST_RANGE;
                else
                    read_value_next = rd_w[DEPTH];
            end
            MODE_LOCATE:
            begin
                found_next = found_x[4:0];
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign count_x = CMP_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            length_reg     <= count_x[4:0];
            empty_reg      <= count_next == '0;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.read_value     = read_value_reg;
    assign rsp.found_position = found_reg;
    assign rsp.list_length    = length_reg;
    assign rsp.is_empty       = empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("length beyond depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (req.mode == MODE_CLEAR) |=> count_reg == '0)
        else $error("clear left entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        acc && ins_ok |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> empty_reg == (count_reg == '0))
        else $error("empty flag disagrees with length");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (req.mode == MODE_INSERT) && !has_room |=> count_reg == $past(count_reg))
        else $error("insert into full list changed length");

endmodule
`default_nettype wire

// ===== bench/tb_positional_ordered_list.sv =====
// testbench for the positional ordered list: random and directed requests against a predictor
`timescale 1ns / 1ps
module tb_positional_ordered_list;
    import pol_pkg::*;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int PHASE_ITEMS  = 335;
    localparam int VALUE_POOL   = 7;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] position;
        logic [7:0] value;
    } list_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_value;
        logic [4:0] found_position;
        logic [4:0] list_length;
        logic       is_empty;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    pol_req_if req_ch ();
    pol_rsp_if rsp_ch ();

    positional_ordered_list uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_req_t pending_reqs[$];
    list_rsp_t expected_results[$];
    list_req_t offered;
    list_rsp_t predicted;
    list_rsp_t want;

    logic [7:0] list_entries [DEPTH];
    int list_len;
    int gen_len;
    int send_idle_pct;
    int stall_pct;
    int hold_reqs;
    int hold_done;
    int hold_left;
    int mismatches;
    int cycle_count;

    always #1 clk = ~clk;

    // predictor: applies one request to the shadow list and gives its result
    task automatic apply_request(input list_req_t r, output list_rsp_t o);
        int pos;
        int i;
        pos = int'(r.position);
        o = '0;
        o.status = ST_DONE;
        case (r.mode)
            MODE_INSERT:
            begin
                if (list_len >= DEPTH)
                    o.status = ST_FULL;
                else if (pos < 1 || pos > list_len + 1)
                    o.status = ST_RANGE;
                else
                begin
                    for (i = list_len; i >= pos; i--)
                        list_entries[i] = list_entries[i - 1];
                    list_entries[pos - 1] = r.value;
                    list_len++;
                end
            end
            MODE_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    o.status = ST_RANGE;
                else
                begin
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_len--;
                end
            end
            MODE_READ:
            begin
                if (pos < 1 || pos > list_len)
                    o.status = ST_RANGE;
                else
                    o.read_value = list_entries[pos - 1];
            end
            MODE_LOCATE:
            begin
                for (i = list_len - 1; i >= 0; i--)
                    if (list_entries[i] == r.value)
                        o.found_position = 5'(i + 1);
            end
            MODE_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        o.list_length = 5'(list_len);
        o.is_empty = (list_len == 0);
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // queues a request and tracks the length the list will have once it is done
    task automatic queue_req(input logic [2:0] mode, input int pos, input int val);
        list_req_t r;
        r.mode = mode;
        r.position = 5'(pos);
        r.value = 8'(val);
        pending_reqs.push_back(r);
        case (mode)
            MODE_INSERT:
                if (gen_len < DEPTH && pos >= 1 && pos <= gen_len + 1)
                    gen_len++;
            MODE_DELETE:
                if (pos >= 1 && pos <= gen_len)
                    gen_len--;
            MODE_CLEAR:
                gen_len = 0;
            default:
                ;
        endcase
    endtask

    task automatic queue_random(input int n);
        int ins_w;
        int sel;
        int pos;
        int val;
        logic [2:0] mode;
        ins_w = 45;
        for (int k = 0; k < n; k++)
        begin
            if (k % 100 == 0)
                ins_w = ($urandom_range(1) != 0) ? 60 : 30;
            sel = int'($urandom_range(99));
            if (sel < ins_w)
                mode = MODE_INSERT;
            else if (sel < ins_w + 20)
                mode = MODE_DELETE;
            else if (sel < ins_w + 33)
                mode = MODE_READ;
            else if (sel < ins_w + 35)
                mode = MODE_CLEAR;
            else if (sel < ins_w + 37)
                mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
            else
                mode = MODE_LOCATE;
            if ($urandom_range(9) == 0)
                pos = int'($urandom_range(31));
            else if (mode == MODE_INSERT)
                pos = int'($urandom_range(gen_len + 1, 1));
            else
                pos = int'($urandom_range((gen_len > 0) ? gen_len : 1, 1));
            // a small pool of values makes locate hits and repeated entries common
            if ($urandom_range(1) != 0)
                val = int'($urandom_range(VALUE_POOL));
            else
                val = int'($urandom_range(255));
            queue_req(mode, pos, val);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || req_ch.valid)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input int n);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        queue_random(n);
        wait_drained();
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_request(offered, predicted);
                expected_results.push_back(predicted);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_reqs.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.mode     <= offered.mode;
                    req_ch.position <= offered.position;
                    req_ch.value    <= offered.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result ready, with long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_done != hold_reqs)
        begin
            hold_done++;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result item with none expected, status %0d length %0d",
                         $time, rsp_ch.status, rsp_ch.list_length);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", int'(want.status), int'(rsp_ch.status));
                check_field("read_value", int'(want.read_value), int'(rsp_ch.read_value));
                check_field("found_position", int'(want.found_position),
                            int'(rsp_ch.found_position));
                check_field("list_length", int'(want.list_length), int'(rsp_ch.list_length));
                check_field("is_empty", int'(want.is_empty), int'(rsp_ch.is_empty));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_READ;
        req_ch.position = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        list_len = 0;
        gen_len = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_left = 0;
        mismatches = 0;
        cycle_count = 0;
        for (int i = 0; i < DEPTH; i++)
            list_entries[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list cases, fill to full with front, end and middle inserts, then edge cases and clear
        queue_req(MODE_READ, 1, 0);
        queue_req(MODE_INSERT, 2, 8'h11);
        queue_req(MODE_LOCATE, 0, 8'h00);
        queue_req(MODE_INSERT, 1, 8'h00);
        queue_req(MODE_INSERT, 2, 8'hFF);
        queue_req(MODE_INSERT, 1, 8'h5A);
        for (int k = 0; k < DEPTH - 3; k++)
            queue_req(MODE_INSERT,
                      (k % 3 == 0) ? 1 : (k % 3 == 1) ? gen_len + 1 : gen_len / 2 + 1,
                      int'($urandom_range(255)));
        queue_req(MODE_INSERT, 0, 8'h33);
        queue_req(MODE_READ, DEPTH, 0);
        queue_req(MODE_DELETE, 31, 0);
        queue_req(MODE_DELETE, 1, 0);
        queue_req(MODE_LOCATE, 0, 8'hFF);
        queue_req(MODE_SPARE_LAST, 1, 8'hFF);
        queue_req(MODE_CLEAR, 0, 0);
        wait_drained();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(61, 0, PHASE_ITEMS);
        run_phase(0, 61, PHASE_ITEMS);
        run_phase(31, 31, PHASE_ITEMS);

        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        stall_pct = 0;
        hold_reqs++;
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
